@@ rtl/cddc_pkg.sv @@
// Shared types, constants and the month-start table for the civil date / day number converter.
// Used by cddc_to_days, cddc_to_civil and civil_date_day_converter.
package cddc_pkg;

  typedef enum logic [1:0] {
    OP_TO_DAYS = 2'd0,
    OP_TO_DATE = 2'd1,
    OP_ADD     = 2'd2,
    OP_NONE    = 2'd3
  } req_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // Calendar constants.
  localparam logic [13:0] YEAR_MAX      = 14'd9999;
  localparam logic [13:0] YEARS_PER_ERA = 14'd400;
  localparam logic [17:0] ERA_DAYS      = 18'd146097;
  localparam logic [17:0] ERA_LAST_DAY  = 18'd146096;
  localparam logic [17:0] CENT_DAYS     = 18'd36524;
  localparam logic [8:0]  YEAR_DAYS     = 9'd365;
  localparam logic [7:0]  MONTH_SPAN    = 8'd153;
  // Offset from day number to days since the start of the era before 0000-03-01.
  localparam logic [23:0] ZZ_BIAS       = 24'd865565;
  localparam logic signed [23:0] DN_MIN = -24'sd719528;
  localparam logic signed [23:0] DN_MAX = 24'sd2932896;

  // Reciprocals for exact division by constants: floor(x * R >> S) over the operand range.
  localparam logic [13:0] RECIP_400    = 14'd10486;   // shift 22, x < 2^14
  localparam logic [9:0]  RECIP_100    = 10'd656;     // shift 16, x < 400
  localparam logic [14:0] RECIP_ERA    = 15'd29398;   // shift 32, may be one low
  localparam logic [17:0] RECIP_1460   = 18'd183860;  // shift 28, x < 2^18
  localparam logic [18:0] RECIP_365    = 19'd367720;  // shift 27, x < 2^18
  localparam logic [10:0] RECIP_153    = 11'd1714;    // shift 18, x < 2048

  typedef struct packed {
    logic        vld;
    status_e     status;
    logic [22:0] day_number;
    logic [21:0] zz;
  } days_res_t;

  typedef struct packed {
    logic        vld;
    status_e     status;
    logic [22:0] day_number;
    logic [8:0]  doy;
    logic [3:0]  mp;
    logic [13:0] yb;
  } civil_res_t;

  // Day of the March-based year on which month index idx starts: (153 * idx + 2) / 5.
  function automatic logic [8:0] month_start(input logic [3:0] idx);
    logic [8:0] res;
    case (idx)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd61;
      4'd3:    res = 9'd92;
      4'd4:    res = 9'd122;
      4'd5:    res = 9'd153;
      4'd6:    res = 9'd184;
      4'd7:    res = 9'd214;
      4'd8:    res = 9'd245;
      4'd9:    res = 9'd275;
      4'd10:   res = 9'd306;
      4'd11:   res = 9'd337;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

@@ rtl/cddc_to_days.sv @@
// Front pipeline: checks the request, turns a date into a day number (or passes one
// through), applies offset and range check. Eight register stages. Depends on cddc_pkg.
module cddc_to_days (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  in_valid_i,
  input  logic [1:0]            req_type_i,
  input  logic [13:0]           year_i,
  input  logic [3:0]            month_i,
  input  logic [4:0]            day_i,
  input  logic signed [22:0]    day_number_i,
  input  logic signed [22:0]    day_offset_i,
  output cddc_pkg::days_res_t   res_o
);
  import cddc_pkg::*;

  logic [7:0] vld_q;

  // Stage 1: field check, March-based year and day of year.
  logic        early;
  logic [3:0]  mi;
  logic        t1_bad_d;
  req_op_e     t1_op_q;
  logic        t1_bad_q;
  logic [13:0] t1_yy_q;
  logic [8:0]  t1_doy_q;
  logic [22:0] t1_dn_q;
  logic [22:0] t1_off_q;

  assign early    = (month_i <= 4'd2);
  assign mi       = early ? (month_i + 4'd9) : (month_i - 4'd3);
  assign t1_bad_d = (req_type_i == OP_NONE) ||
                    ((req_type_i != OP_TO_DATE) &&
                     ((month_i == 4'd0) || (month_i > 4'd12) || (day_i == 5'd0) ||
                      (year_i > YEAR_MAX)));

  // Stage 2: era of the shifted year.
  logic [27:0] era_prod;
  req_op_e     t2_op_q;
  logic        t2_bad_q;
  logic [13:0] t2_yy_q;
  logic [8:0]  t2_doy_q;
  logic [22:0] t2_dn_q;
  logic [22:0] t2_off_q;
  logic [4:0]  t2_era_q;

  assign era_prod = 28'(t1_yy_q) * 28'(RECIP_400);

  // Stage 3: year of era and the day number of the era start.
  logic [13:0] yy_rem;
  req_op_e     t3_op_q;
  logic        t3_bad_q;
  logic [8:0]  t3_yoe_q;
  logic [8:0]  t3_doy_q;
  logic [22:0] t3_dn_q;
  logic [22:0] t3_off_q;
  logic [23:0] t3_base_q;

  assign yy_rem = t2_yy_q - 14'(t2_era_q) * YEARS_PER_ERA;

  // Stage 4: days in the whole years before this one.
  logic [17:0] c100_prod;
  req_op_e     t4_op_q;
  logic        t4_bad_q;
  logic [17:0] t4_ydays_q;
  logic [1:0]  t4_c100_q;
  logic [8:0]  t4_doy_q;
  logic [22:0] t4_dn_q;
  logic [22:0] t4_off_q;
  logic [23:0] t4_base_q;

  assign c100_prod = 18'(t3_yoe_q) * 18'(RECIP_100);

  // Stage 5: day of era.
  req_op_e     t5_op_q;
  logic        t5_bad_q;
  logic [17:0] t5_doe_q;
  logic [22:0] t5_dn_q;
  logic [22:0] t5_off_q;
  logic [23:0] t5_base_q;

  // Stage 6: day number of the date.
  req_op_e     t6_op_q;
  logic        t6_bad_q;
  logic [23:0] t6_z0_q;
  logic [22:0] t6_dn_q;
  logic [22:0] t6_off_q;

  // Stage 7: operation select and offset.
  logic [23:0] off_ext;
  logic [23:0] z_sel;
  logic        t7_bad_q;
  logic signed [23:0] t7_z_q;

  assign off_ext = (t6_op_q == OP_ADD) ? {t6_off_q[22], t6_off_q} : 24'd0;
  assign z_sel   = (t6_op_q == OP_TO_DATE) ? {t6_dn_q[22], t6_dn_q} : (t6_z0_q + off_ext);

  // Stage 8: status and the biased count for the reverse conversion.
  logic [23:0] zz_full;
  status_e     t8_st_d;
  status_e     t8_st_q;
  logic [22:0] t8_dn_q;
  logic [21:0] t8_zz_q;

  assign zz_full = t7_z_q + ZZ_BIAS;

  always_comb begin
    if (t7_bad_q) begin
      t8_st_d = ST_BAD;
    end else if ((t7_z_q < DN_MIN) || (t7_z_q > DN_MAX)) begin
      t8_st_d = ST_RANGE;
    end else begin
      t8_st_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[6:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      t1_op_q    <= req_op_e'(req_type_i);
      t1_bad_q   <= t1_bad_d;
      t1_yy_q    <= year_i + YEARS_PER_ERA - 14'(early);
      t1_doy_q   <= month_start(mi) + 9'(day_i) - 9'd1;
      t1_dn_q    <= day_number_i;
      t1_off_q   <= day_offset_i;

      t2_op_q    <= t1_op_q;
      t2_bad_q   <= t1_bad_q;
      t2_yy_q    <= t1_yy_q;
      t2_doy_q   <= t1_doy_q;
      t2_dn_q    <= t1_dn_q;
      t2_off_q   <= t1_off_q;
      t2_era_q   <= era_prod[26:22];

      t3_op_q    <= t2_op_q;
      t3_bad_q   <= t2_bad_q;
      t3_yoe_q   <= yy_rem[8:0];
      t3_doy_q   <= t2_doy_q;
      t3_dn_q    <= t2_dn_q;
      t3_off_q   <= t2_off_q;
      t3_base_q  <= 24'(t2_era_q) * 24'(ERA_DAYS) - ZZ_BIAS;

      t4_op_q    <= t3_op_q;
      t4_bad_q   <= t3_bad_q;
      t4_ydays_q <= 18'(t3_yoe_q) * 18'(YEAR_DAYS) + 18'(t3_yoe_q[8:2]);
      t4_c100_q  <= c100_prod[17:16];
      t4_doy_q   <= t3_doy_q;
      t4_dn_q    <= t3_dn_q;
      t4_off_q   <= t3_off_q;
      t4_base_q  <= t3_base_q;

      t5_op_q    <= t4_op_q;
      t5_bad_q   <= t4_bad_q;
      t5_doe_q   <= t4_ydays_q - 18'(t4_c100_q) + 18'(t4_doy_q);
      t5_dn_q    <= t4_dn_q;
      t5_off_q   <= t4_off_q;
      t5_base_q  <= t4_base_q;

      t6_op_q    <= t5_op_q;
      t6_bad_q   <= t5_bad_q;
      t6_z0_q    <= t5_base_q + 24'(t5_doe_q);
      t6_dn_q    <= t5_dn_q;
      t6_off_q   <= t5_off_q;

      t7_bad_q   <= t6_bad_q;
      t7_z_q     <= z_sel;

      t8_st_q    <= t8_st_d;
      t8_dn_q    <= t7_z_q[22:0];
      t8_zz_q    <= zz_full[21:0];
    end
  end

  assign res_o.vld        = vld_q[7];
  assign res_o.status     = t8_st_q;
  assign res_o.day_number = t8_dn_q;
  assign res_o.zz         = t8_zz_q;

endmodule

@@ rtl/cddc_to_civil.sv @@
// Back pipeline: splits a biased day count into era, year of era, day of year and
// month index. Nine register stages. Depends on cddc_pkg.
module cddc_to_civil (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  cddc_pkg::days_res_t   days_i,
  output cddc_pkg::civil_res_t  res_o
);
  import cddc_pkg::*;

  typedef struct packed {
    status_e     status;
    logic [22:0] dn;
  } side_t;

  logic [8:0] vld_q;
  side_t      side_q [9];

  // Stage 1: era estimate, exact or one low.
  logic [36:0] q_prod;
  logic [21:0] c1_zz_q;
  logic [4:0]  c1_q_q;

  assign q_prod = 37'(days_i.zz) * 37'(RECIP_ERA);

  // Stage 2: remainder against the estimate.
  logic [21:0] rem_full;
  logic [18:0] c2_r_q;
  logic [4:0]  c2_q_q;

  assign rem_full = c1_zz_q - 22'(c1_q_q) * 22'(ERA_DAYS);

  // Stage 3: correct the estimate.
  logic [4:0]  c3_era_q;
  logic [17:0] c3_doe_q;

  // Stage 4: leap corrections of the day of era.
  logic [35:0] c1460_prod;
  logic [2:0]  cent_cnt;
  logic [4:0]  c4_era_q;
  logic [17:0] c4_doe_q;
  logic [6:0]  c4_c1460_q;
  logic [2:0]  c4_cent_q;
  logic        c4_last_q;

  assign c1460_prod = 36'(c3_doe_q) * 36'(RECIP_1460);
  assign cent_cnt   = 3'(c3_doe_q >= CENT_DAYS) +
                      3'(c3_doe_q >= 18'(2 * CENT_DAYS)) +
                      3'(c3_doe_q >= 18'(3 * CENT_DAYS)) +
                      3'(c3_doe_q >= ERA_LAST_DAY);

  // Stage 5: day of era with leap days taken out.
  logic [4:0]  c5_era_q;
  logic [17:0] c5_doe_q;
  logic [17:0] c5_t_q;

  // Stage 6: year of era.
  logic [36:0] yoe_prod;
  logic [4:0]  c6_era_q;
  logic [17:0] c6_doe_q;
  logic [8:0]  c6_yoe_q;

  assign yoe_prod = 37'(c5_t_q) * 37'(RECIP_365);

  // Stage 7: days before this year and the March-based year.
  logic [17:0] c100_prod;
  logic [17:0] c7_doe_q;
  logic [17:0] c7_ydays_q;
  logic [1:0]  c7_c100_q;
  logic [13:0] c7_yb_q;

  assign c100_prod = 18'(c6_yoe_q) * 18'(RECIP_100);

  // Stage 8: day of year.
  logic [17:0] doy_full;
  logic [8:0]  c8_doy_q;
  logic [13:0] c8_yb_q;

  assign doy_full = c7_doe_q - (c7_ydays_q - 18'(c7_c100_q));

  // Stage 9: month index.
  logic [10:0] mp_arg;
  logic [21:0] mp_prod;
  logic [8:0]  c9_doy_q;
  logic [3:0]  c9_mp_q;
  logic [13:0] c9_yb_q;

  assign mp_arg  = 11'(c8_doy_q) * 11'd5 + 11'd2;
  assign mp_prod = 22'(mp_arg) * 22'(RECIP_153);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[7:0], days_i.vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      side_q[0] <= '{status: days_i.status, dn: days_i.day_number};
      for (int i = 1; i < 9; i++) begin
        side_q[i] <= side_q[i-1];
      end

      c1_zz_q    <= days_i.zz;
      c1_q_q     <= q_prod[36:32];

      c2_r_q     <= rem_full[18:0];
      c2_q_q     <= c1_q_q;

      if (c2_r_q >= 19'(ERA_DAYS)) begin
        c3_era_q <= c2_q_q + 5'd1;
        c3_doe_q <= 18'(c2_r_q - 19'(ERA_DAYS));
      end else begin
        c3_era_q <= c2_q_q;
        c3_doe_q <= c2_r_q[17:0];
      end

      c4_era_q   <= c3_era_q;
      c4_doe_q   <= c3_doe_q;
      c4_c1460_q <= c1460_prod[34:28];
      c4_cent_q  <= cent_cnt;
      c4_last_q  <= (c3_doe_q == ERA_LAST_DAY);

      c5_era_q   <= c4_era_q;
      c5_doe_q   <= c4_doe_q;
      c5_t_q     <= c4_doe_q - 18'(c4_c1460_q) + 18'(c4_cent_q) - 18'(c4_last_q);

      c6_era_q   <= c5_era_q;
      c6_doe_q   <= c5_doe_q;
      c6_yoe_q   <= yoe_prod[35:27];

      c7_doe_q   <= c6_doe_q;
      c7_ydays_q <= 18'(c6_yoe_q) * 18'(YEAR_DAYS) + 18'(c6_yoe_q[8:2]);
      c7_c100_q  <= c100_prod[17:16];
      c7_yb_q    <= 14'(c6_yoe_q) + 14'(c6_era_q) * YEARS_PER_ERA - YEARS_PER_ERA;

      c8_doy_q   <= doy_full[8:0];
      c8_yb_q    <= c7_yb_q;

      c9_doy_q   <= c8_doy_q;
      c9_mp_q    <= mp_prod[21:18];
      c9_yb_q    <= c8_yb_q;
    end
  end

  assign res_o.vld        = vld_q[8];
  assign res_o.status     = side_q[8].status;
  assign res_o.day_number = side_q[8].dn;
  assign res_o.doy        = c9_doy_q;
  assign res_o.mp         = c9_mp_q;
  assign res_o.yb         = c9_yb_q;

endmodule

@@ rtl/civil_date_day_converter.sv @@
// Pipeline depth: 18 register stages, the last of which is the output register.
// Throughput: one item per cycle when not stalled; every stage registered, no loop back.
// The whole pipeline advances together and freezes only while a held result is stalled.
// Reset clears the valid bits of every stage; data registers are not reset.
// Depends on cddc_pkg, cddc_to_days and cddc_to_civil.
module civil_date_day_converter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic [13:0]        year_i,
  input  logic [3:0]         month_i,
  input  logic [4:0]         day_i,
  input  logic signed [22:0] day_number_i,
  input  logic signed [22:0] day_offset_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [13:0]        out_year_o,
  output logic [3:0]         out_month_o,
  output logic [4:0]         out_day_o,
  output logic signed [22:0] out_day_number_o,
  output logic [1:0]         status_o
);
  import cddc_pkg::*;

  logic       adv;
  days_res_t  days;
  civil_res_t civil;

  logic        out_vld_q;
  logic [13:0] out_year_q;
  logic [3:0]  out_month_q;
  logic [4:0]  out_day_q;
  logic [22:0] out_dn_q;
  status_e     out_st_q;

  logic        ok;
  logic        wrap;
  logic [3:0]  month_d;
  logic [4:0]  day_d;
  logic [8:0]  day_full;

  // A held result that is not taken freezes every stage.
  assign adv        = !(out_vld_q && out_stall_i);
  assign in_stall_o = !adv;

  cddc_to_days u_to_days (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_valid_i  (in_valid_i),
    .req_type_i  (req_type_i),
    .year_i      (year_i),
    .month_i     (month_i),
    .day_i       (day_i),
    .day_number_i(day_number_i),
    .day_offset_i(day_offset_i),
    .res_o       (days)
  );

  cddc_to_civil u_to_civil (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .adv_i (adv),
    .days_i(days),
    .res_o (civil)
  );

  // January and February belong to the following civil year.
  assign ok       = (civil.status == ST_OK);
  assign wrap     = (civil.mp >= 4'd10);
  assign month_d  = wrap ? (civil.mp - 4'd9) : (civil.mp + 4'd3);
  assign day_full = civil.doy - month_start(civil.mp) + 9'd1;
  assign day_d    = day_full[4:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= civil.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_st_q    <= civil.status;
      out_year_q  <= ok ? (civil.yb + 14'(wrap)) : 14'd0;
      out_month_q <= ok ? month_d : 4'd0;
      out_day_q   <= ok ? day_d : 5'd0;
      out_dn_q    <= ok ? civil.day_number : 23'd0;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign out_year_o       = out_year_q;
  assign out_month_o      = out_month_q;
  assign out_day_o        = out_day_q;
  assign out_day_number_o = out_dn_q;
  assign status_o         = out_st_q;

endmodule
